[rtl/mtem_pkg.sv]
// Shared types and constants of the multi-table exact-match block.
// No dependencies; every other file of the block imports this package.
package mtem_pkg;

  localparam int unsigned NumTablesDef = 8;
  localparam int unsigned EntriesPerTableDef = 64;
  localparam int unsigned KeyBitsDef = 64;

  localparam int unsigned TableNumW = 3;
  localparam int unsigned KeyW = 64;
  localparam int unsigned ActionIdW = 8;
  localparam int unsigned DataHighW = 64;
  localparam int unsigned DataMidW = 64;
  localparam int unsigned DataLowW = 32;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [ActionIdW-1:0] id;
    logic [DataHighW-1:0] high;
    logic [DataMidW-1:0]  mid;
    logic [DataLowW-1:0]  low;
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

[rtl/mtem_if.sv]
// Request and response channel interfaces of the multi-table exact-match block.
// Depends on mtem_pkg for the field widths.
interface mtem_req_if;
  import mtem_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [TableNumW-1:0] table_number;
  logic [KeyW-1:0]      match_key;
  logic [ActionIdW-1:0] new_action_id;
  logic [DataHighW-1:0] new_data_high;
  logic [DataMidW-1:0]  new_data_mid;
  logic [DataLowW-1:0]  new_data_low;

  modport source (
    output valid, command, table_number, match_key, new_action_id,
    output new_data_high, new_data_mid, new_data_low,
    input  ready
  );

  modport sink (
    input  valid, command, table_number, match_key, new_action_id,
    input  new_data_high, new_data_mid, new_data_low,
    output ready
  );
endinterface

interface mtem_rsp_if;
  import mtem_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ActionIdW-1:0] hit_action_id;
  logic [DataHighW-1:0] hit_data_high;
  logic [DataMidW-1:0]  hit_data_mid;
  logic [DataLowW-1:0]  hit_data_low;

  modport source (
    output valid, status, hit_action_id, hit_data_high, hit_data_mid, hit_data_low,
    input  ready
  );

  modport sink (
    input  valid, status, hit_action_id, hit_data_high, hit_data_mid, hit_data_low,
    output ready
  );
endinterface

[rtl/mtem_store.sv]
// Entry store: synchronous key and action memories, one write and one read port.
// Depends on mtem_pkg for the action word type.
module mtem_store #(
  parameter int unsigned NUM_TABLES        = mtem_pkg::NumTablesDef,
  parameter int unsigned ENTRIES_PER_TABLE = mtem_pkg::EntriesPerTableDef,
  parameter int unsigned KEY_BITS          = mtem_pkg::KeyBitsDef,
  localparam int unsigned TblW  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
  localparam int unsigned EntW  = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1,
  localparam int unsigned AddrW = TblW + EntW
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  mtem_pkg::action_t     wr_action_i,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output mtem_pkg::action_t     rd_action_o
);
  import mtem_pkg::*;

  localparam int unsigned Depth = NUM_TABLES * (1 << EntW);

  logic [KEY_BITS-1:0] key_mem [Depth];
  action_t             action_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]    <= wr_key_i;
      action_mem[wr_addr_i] <= wr_action_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o    <= key_mem[rd_addr_i];
      rd_action_o <= action_mem[rd_addr_i];
    end
  end

endmodule

[rtl/multi_table_exact_match.sv]
// Multi-table exact-match lookup: top level with control and fill counts.
// Depends on mtem_pkg, mtem_if and mtem_store.
//
// Requests arrive on req_i: an insert appends a key, an action id and a
// 160-bit action data word to the addressed table; a lookup scans that
// table from its oldest entry and returns the first entry with an equal key.
// Each request gives exactly one response on rsp_o, in request order.
// A request passes through the execute and done states, and a lookup of a
// filled table through the scan state between them. The scan reads at most
// the table's fill count of entries, since the single read port of the entry
// store is visited once per entry; a hit ends the scan early.
// One request is in work at a time. The response sits in an output
// register, so a new request is taken while a response waits; a stalled
// receiver holds the block only when the next response is ready to leave.
// Reset clears all fill counts, so every table starts empty; the entry
// store itself is not cleared and is read only below the fill count.
module multi_table_exact_match #(
  parameter int unsigned NUM_TABLES        = mtem_pkg::NumTablesDef,
  parameter int unsigned ENTRIES_PER_TABLE = mtem_pkg::EntriesPerTableDef,
  parameter int unsigned KEY_BITS          = mtem_pkg::KeyBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtem_req_if.sink   req_i,
  mtem_rsp_if.source rsp_o
);
  import mtem_pkg::*;

  localparam int unsigned TblW  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned EntW  = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES_PER_TABLE + 1);
  localparam int unsigned AddrW = TblW + EntW;
  localparam logic [CntW-1:0] Capacity = CntW'(ENTRIES_PER_TABLE);

  state_e state_q, state_d;

  logic                req_fire;
  logic                tbl_ok_q;
  logic                cmd_q;
  logic [TblW-1:0]     tbl_q;
  logic [KEY_BITS-1:0] key_q;
  action_t             action_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     fill_q [NUM_TABLES];
  logic                fill_we;

  status_e res_status_q, res_status_d;
  action_t res_action_q, res_action_d;

  logic    out_valid_q, out_valid_d;
  logic    out_load;
  status_e out_status_q;
  action_t out_action_q;

  logic                mem_wr_en;
  logic                mem_rd_en;
  logic [AddrW-1:0]    mem_wr_addr;
  logic [AddrW-1:0]    mem_rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  action_t             rd_action;
  logic                hit;

  assign req_fire    = req_i.valid && req_i.ready;
  assign hit         = (rd_key == key_q);
  assign mem_wr_addr = {tbl_q, cnt_q[EntW-1:0]};
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  mtem_store #(
    .NUM_TABLES        (NUM_TABLES),
    .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
    .KEY_BITS          (KEY_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (mem_wr_en),
    .wr_addr_i   (mem_wr_addr),
    .wr_key_i    (key_q),
    .wr_action_i (action_q),
    .rd_en_i     (mem_rd_en),
    .rd_addr_i   (mem_rd_addr),
    .rd_key_o    (rd_key),
    .rd_action_o (rd_action)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!tbl_ok_q || cmd_q == CMD_INSERT || cnt_q == '0) state_d = S_DONE;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        if (hit || idx_q == cnt_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready  = (state_q == S_IDLE);
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = {tbl_q, idx_q[EntW-1:0]};
    fill_we      = 1'b0;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_action_d = res_action_q;
    case (state_q)
      S_EXEC: begin
        res_action_d = '0;
        if (cmd_q == CMD_INSERT) begin
          if (tbl_ok_q && cnt_q != Capacity) begin
            mem_wr_en    = 1'b1;
            fill_we      = 1'b1;
            res_status_d = ST_OK;
          end else begin
            res_status_d = ST_FULL;
          end
        end else if (!tbl_ok_q || cnt_q == '0) begin
          res_status_d = ST_MISS;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {tbl_q, EntW'(0)};
          idx_d       = CntW'(1);
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status_d = ST_OK;
          res_action_d = rd_action;
        end else if (idx_q == cnt_q) begin
          res_status_d = ST_MISS;
          res_action_d = '0;
        end else begin
          mem_rd_en = 1'b1;
          idx_d     = idx_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int t = 0; t < NUM_TABLES; t++) fill_q[t] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fill_we) fill_q[tbl_q] <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q    <= req_i.command;
      tbl_q    <= TblW'(req_i.table_number);
      tbl_ok_q <= int'(req_i.table_number) < NUM_TABLES;
      key_q    <= req_i.match_key[KEY_BITS-1:0];
      action_q <= '{id:   req_i.new_action_id,
                    high: req_i.new_data_high,
                    mid:  req_i.new_data_mid,
                    low:  req_i.new_data_low};
      cnt_q    <= (int'(req_i.table_number) < NUM_TABLES)
                  ? fill_q[TblW'(req_i.table_number)] : '0;
    end
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_action_q <= res_action_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_action_q <= res_action_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.hit_action_id = out_action_q.id;
  assign rsp_o.hit_data_high = out_action_q.high;
  assign rsp_o.hit_data_mid  = out_action_q.mid;
  assign rsp_o.hit_data_low  = out_action_q.low;

endmodule

[rtl/mtem_checker.sv]
// Port-level checker of the multi-table exact-match block and its bind.
// Depends on mtem_pkg for the status codes; attaches to multi_table_exact_match.
module mtem_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         req_valid_i,
  input logic         req_ready_i,
  input logic         rsp_valid_i,
  input logic         rsp_ready_i,
  input logic [1:0]   rsp_status_i,
  input logic [7:0]   rsp_action_id_i,
  input logic [63:0]  rsp_data_high_i,
  input logic [63:0]  rsp_data_mid_i,
  input logic [31:0]  rsp_data_low_i
);
  import mtem_pkg::*;

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] pend_q;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_action_id_i) && $stable(rsp_data_low_i))
    else $error("response changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i |-> pend_q <= 2'd1)
    else $error("request taken while another is still in work");

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response without an outstanding request");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_action_id_i == '0
      && rsp_data_high_i == '0 && rsp_data_mid_i == '0 && rsp_data_low_i == '0)
    else $error("miss or full response carries action data");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && pend_q == 2'd0 |=> !rsp_valid_i)
    else $error("response appeared in the cycle after an idle request");

endmodule

bind multi_table_exact_match mtem_checker u_mtem_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_action_id_i (rsp_o.hit_action_id),
  .rsp_data_high_i (rsp_o.hit_data_high),
  .rsp_data_mid_i  (rsp_o.hit_data_mid),
  .rsp_data_low_i  (rsp_o.hit_data_low)
);

[bench/tb.sv]
// Testbench of multi_table_exact_match: directed and random inserts and lookups,
// checked one response at a time against a behavioural copy of the tables.
// Depends on mtem_pkg, the channel interfaces in mtem_if and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtem_pkg::*;

  localparam int unsigned NumTables   = NumTablesDef;
  localparam int unsigned Entries     = EntriesPerTableDef;
  localparam logic [KeyW-1:0] KeyMask = {KeyW{1'b1}} >> (KeyW - KeyBitsDef);
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned IdlePercent = 23;

  typedef struct packed {
    logic                 command;
    logic [TableNumW-1:0] table_number;
    logic [KeyW-1:0]      key;
    action_t              act;
  } request_t;

  typedef struct packed {
    status_e status;
    action_t act;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        quiet = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  request_t queued_requests[$];
  answer_t  expected_answers[$];
  request_t on_bus;
  answer_t  oldest_answer;

  int unsigned     table_fill [NumTables];
  logic [KeyW-1:0] table_keys [NumTables][Entries];
  action_t         table_actions [NumTables][Entries];

  logic [KeyW-1:0]      stored_keys[$];
  logic [TableNumW-1:0] stored_tables[$];

  mtem_req_if req_if();
  mtem_rsp_if rsp_if();

  multi_table_exact_match DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic answer_t match_or_store(request_t r);
    answer_t         a;
    logic [KeyW-1:0] k;
    int unsigned     n;
    logic            found;
    a.status = ST_MISS;
    a.act    = '0;
    k        = r.key & KeyMask;
    found    = 1'b0;
    if (r.table_number >= NumTables) begin
      a.status = (r.command == CMD_INSERT) ? ST_FULL : ST_MISS;
    end else if (r.command == CMD_INSERT) begin
      n = table_fill[r.table_number];
      if (n >= Entries) begin
        a.status = ST_FULL;
      end else begin
        table_keys[r.table_number][n]    = k;
        table_actions[r.table_number][n] = r.act;
        table_fill[r.table_number]       = n + 1;
        a.status = ST_OK;
      end
    end else begin
      for (int i = 0; i < table_fill[r.table_number] && !found; i++) begin
        if (table_keys[r.table_number][i] == k) begin
          found    = 1'b1;
          a.status = ST_OK;
          a.act    = table_actions[r.table_number][i];
        end
      end
    end
    return a;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic enqueue(request_t r);
    queued_requests.push_back(r);
    if (r.command == CMD_INSERT) begin
      stored_keys.push_back(r.key);
      stored_tables.push_back(r.table_number);
    end
  endtask

  task automatic push_request(logic cmd, int unsigned tbl, logic [KeyW-1:0] key,
                              logic [ActionIdW-1:0] id, logic [DataHighW-1:0] hi,
                              logic [DataMidW-1:0] mid, logic [DataLowW-1:0] lo);
    request_t r;
    r.command      = cmd;
    r.table_number = TableNumW'(tbl);
    r.key          = key;
    r.act.id       = id;
    r.act.high     = hi;
    r.act.mid      = mid;
    r.act.low      = lo;
    enqueue(r);
  endtask

  task automatic queue_random_requests(int unsigned count);
    request_t    r;
    int unsigned pick;
    int unsigned idx;
    repeat (count) begin
      r.command = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_LOOKUP;
      if ($urandom_range(99) < 40) begin
        r.table_number = TableNumW'($urandom_range(1));
      end else begin
        r.table_number = TableNumW'($urandom_range(NumTables - 1));
      end
      pick = $urandom_range(99);
      if (stored_keys.size() != 0 && pick < ((r.command == CMD_INSERT) ? 20 : 65)) begin
        idx   = $urandom_range(stored_keys.size() - 1);
        r.key = stored_keys[idx];
        if (r.command == CMD_LOOKUP && $urandom_range(99) < 70) begin
          r.table_number = stored_tables[idx];
        end
        if (r.command == CMD_LOOKUP && $urandom_range(99) < 10) begin
          r.key[$urandom_range(KeyW - 1)] ^= 1'b1;
        end
      end else if (pick < 80) begin
        r.key = {$urandom, $urandom};
      end else if (pick < 92) begin
        r.key = KeyW'($urandom_range(15));
      end else begin
        r.key = ($urandom_range(1) != 0) ? '1 : {1'b1, {(KeyW - 1){1'b0}}};
      end
      r.act.id   = ActionIdW'($urandom);
      r.act.high = {$urandom, $urandom};
      r.act.mid  = {$urandom, $urandom};
      r.act.low  = $urandom;
      pick = $urandom_range(19);
      if (pick == 0) begin
        r.act = '1;
      end else if (pick == 1) begin
        r.act = '0;
      end
      enqueue(r);
    end
  endtask

  task automatic wait_for_drain();
    while (queued_requests.size() != 0 || req_if.valid || expected_answers.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Request driver: predicts the answer of each request at the edge it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_answers.push_back(match_or_store(on_bus));
      end
      if (!req_if.valid || req_if.ready) begin
        if (queued_requests.size() != 0 && (quiet || $urandom_range(99) >= IdlePercent)) begin
          on_bus = queued_requests.pop_front();
          req_if.valid         <= 1'b1;
          req_if.command       <= on_bus.command;
          req_if.table_number  <= on_bus.table_number;
          req_if.match_key     <= on_bus.key;
          req_if.new_action_id <= on_bus.act.id;
          req_if.new_data_high <= on_bus.act.high;
          req_if.new_data_mid  <= on_bus.act.mid;
          req_if.new_data_low  <= on_bus.act.low;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: response with no request outstanding, expected none, got status %0d",
                   $time, rsp_if.status);
          mismatches++;
        end else begin
          oldest_answer = expected_answers.pop_front();
          compare_field("status", oldest_answer.status, rsp_if.status);
          compare_field("hit_action_id", oldest_answer.act.id, rsp_if.hit_action_id);
          compare_field("hit_data_high", oldest_answer.act.high, rsp_if.hit_data_high);
          compare_field("hit_data_mid", oldest_answer.act.mid, rsp_if.hit_data_mid);
          compare_field("hit_data_low", oldest_answer.act.low, rsp_if.hit_data_low);
        end
      end
      rsp_if.ready <= quiet || $urandom_range(99) >= IdlePercent;
    end
  end

  // Watchdog: counts cycles with work outstanding in which neither a request nor a response moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (queued_requests.size() == 0 && !req_if.valid && expected_answers.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    for (int t = 0; t < NumTables; t++) begin
      table_fill[t] = 0;
    end
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.command       = CMD_LOOKUP;
    req_if.table_number  = '0;
    req_if.match_key     = '0;
    req_if.new_action_id = '0;
    req_if.new_data_high = '0;
    req_if.new_data_mid  = '0;
    req_if.new_data_low  = '0;
    rsp_if.ready         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // An empty table, duplicate keys where the oldest entry must win, the key
    // and data extremes, and keys that live only in another table.
    push_request(CMD_LOOKUP, 3, '0, '0, '0, '0, '0);
    push_request(CMD_INSERT, 0, '0, 8'h00, '0, '0, '0);
    push_request(CMD_INSERT, 0, '1, 8'hff, '1, '1, '1);
    push_request(CMD_INSERT, 0, '0, 8'h3c, 64'ha5a5_a5a5_a5a5_a5a5,
                 64'h5a5a_5a5a_5a5a_5a5a, 32'ha5a5_a5a5);
    push_request(CMD_INSERT, 7, 64'h8000_0000_0000_0000, 8'h81,
                 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'h8000_0001);
    push_request(CMD_INSERT, 7, 64'h1, 8'h7e, 64'h8000_0000_0000_0000,
                 64'h1, 32'hffff_fffe);
    push_request(CMD_LOOKUP, 0, '0, 8'hff, '1, '1, '1);
    push_request(CMD_LOOKUP, 0, '1, '0, '0, '0, '0);
    push_request(CMD_LOOKUP, 7, 64'h8000_0000_0000_0000, '0, '0, '0, '0);
    push_request(CMD_LOOKUP, 7, 64'h1, '0, '0, '0, '0);
    push_request(CMD_LOOKUP, 7, '0, '0, '0, '0, '0);
    push_request(CMD_LOOKUP, 0, 64'h1, '0, '0, '0, '0);
    push_request(CMD_LOOKUP, 0, 64'h7fff_ffff_ffff_ffff, '0, '0, '0, '0);
    for (int t = 1; t < 7; t++) begin
      push_request(CMD_INSERT, t, 64'hdead_beef_0000_0000 | KeyW'(t), ActionIdW'(t),
                   {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    end
    push_request(CMD_LOOKUP, 4, 64'hdead_beef_0000_0004, '0, '0, '0, '0);
    push_request(CMD_LOOKUP, 5, 64'hdead_beef_0000_0004, '0, '0, '0, '0);
    wait_for_drain();

    queue_random_requests(400);
    wait_for_drain();
    quiet = 1'b1;
    queue_random_requests(300);
    wait_for_drain();
    quiet = 1'b0;
    queue_random_requests(400);
    wait_for_drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mtem_pkg.sv
rtl/mtem_if.sv
rtl/mtem_store.sv
rtl/multi_table_exact_match.sv
rtl/mtem_checker.sv
bench/tb.sv
